FILE: rtl/core/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Shared types, constants and helpers of the pixel stream decimator.
// ----------------------------------------------------------------------------
package psd_pkg;

   localparam int MAX_WIDTH       = 4096;
   localparam int BYTES_PER_PIXEL = 3;

   localparam int PIX_W   = 24;
   localparam int LIM_W   = 13;
   localparam int CNT_W   = 12;
   localparam int INDEX_W = 2;

   localparam logic [PIX_W-1:0] PIX_MASK =
      (BYTES_PER_PIXEL * 8 >= PIX_W) ? {PIX_W{1'b1}} :
      PIX_W'((64'd1 << (BYTES_PER_PIXEL * 8)) - 64'd1);

   localparam logic [LIM_W-1:0] MAX_LIMIT = LIM_W'(MAX_WIDTH);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [INDEX_W-1:0] {
      CSR_IN_WIDTH      = 2'd0,
      CSR_OUT_WIDTH     = 2'd1,
      CSR_STEP          = 2'd2,
      CSR_KEPT_PER_LINE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [LIM_W-1:0] in_width;
      logic [LIM_W-1:0] out_width;
      logic [LIM_W-1:0] step;
      logic [LIM_W-1:0] kept_per_line;
   } cfg_type;

   typedef struct packed {
      logic             has_kept;
      logic             has_pad;
      logic [PIX_W-1:0] pixel;
      logic             kept_end;
      logic [LIM_W-1:0] pad_run;
   } entry_type;

   // saturate at the maximum width, optionally forcing zero up to one
   function automatic logic [LIM_W-1:0] clamp_limit(input logic [LIM_W-1:0] v,
                                                    input logic floor_one);
      logic [LIM_W-1:0] r;
      r = (v > MAX_LIMIT) ? MAX_LIMIT : v;
      if (floor_one && (r == '0)) begin
         r = LIM_W'(1);
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Tracks row and column position and classifies each input pixel into
// a kept pixel, a padding run, both or nothing.
// ----------------------------------------------------------------------------
module psd_front (
   input  logic                          clock,
   input  logic                          reset,
   input  psd_pkg::cfg_type              cfg,
   input  logic                          accept,
   input  logic [psd_pkg::PIX_W-1:0]     pixel,
   output logic                          push,
   output psd_pkg::entry_type            entry
);

   logic [psd_pkg::CNT_W-1:0] column_count_ff, column_count_in;
   logic [psd_pkg::CNT_W-1:0] column_phase_ff, column_phase_in;
   logic [psd_pkg::CNT_W-1:0] row_phase_ff, row_phase_in;
   logic [psd_pkg::LIM_W-1:0] kept_count_ff, kept_count_in;

   logic [psd_pkg::LIM_W-1:0] iw, ow, st, kp_raw, kp;
   logic [psd_pkg::LIM_W-1:0] col_next, cph_next, rph_next;
   logic [psd_pkg::LIM_W:0]   kept_plus;
   logic [psd_pkg::LIM_W-1:0] kept_after;
   logic                      row_kept, row_end, keep, pad;

   always_comb begin
      iw     = psd_pkg::clamp_limit(cfg.in_width, 1'b1);
      ow     = psd_pkg::clamp_limit(cfg.out_width, 1'b1);
      st     = psd_pkg::clamp_limit(cfg.step, 1'b1);
      kp_raw = psd_pkg::clamp_limit(cfg.kept_per_line, 1'b0);
      kp     = (kp_raw > ow) ? ow : kp_raw;

      col_next = {1'b0, column_count_ff} + psd_pkg::LIM_W'(1);
      cph_next = {1'b0, column_phase_ff} + psd_pkg::LIM_W'(1);
      rph_next = {1'b0, row_phase_ff} + psd_pkg::LIM_W'(1);

      row_kept = (row_phase_ff == '0);
      row_end  = (col_next >= iw);
      keep     = row_kept && (column_phase_ff == '0) && (kept_count_ff < kp);

      kept_plus  = {1'b0, kept_count_ff} + (psd_pkg::LIM_W + 1)'(1);
      kept_after = keep ? kept_plus[psd_pkg::LIM_W-1:0] : kept_count_ff;
      pad        = row_end && row_kept && (kept_after < ow);

      entry.has_kept = keep;
      entry.has_pad  = pad;
      entry.pixel    = pixel & psd_pkg::PIX_MASK;
      entry.kept_end = (kept_plus >= {1'b0, ow});
      entry.pad_run  = ow - kept_after;

      push = accept && (keep || pad);
   end

   always_comb begin
      column_count_in = column_count_ff;
      column_phase_in = column_phase_ff;
      row_phase_in    = row_phase_ff;
      kept_count_in   = kept_count_ff;
      if (accept) begin
         if (row_end) begin
            column_count_in = '0;
            column_phase_in = '0;
            kept_count_in   = '0;
            row_phase_in    = (rph_next >= st) ? '0 : rph_next[psd_pkg::CNT_W-1:0];
         end else begin
            column_count_in = col_next[psd_pkg::CNT_W-1:0];
            column_phase_in = (cph_next >= st) ? '0 : cph_next[psd_pkg::CNT_W-1:0];
            kept_count_in   = kept_after;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         column_phase_ff <= '0;
         row_phase_ff    <= '0;
         kept_count_ff   <= '0;
      end else begin
         column_count_ff <= column_count_in;
         column_phase_ff <= column_phase_in;
         row_phase_ff    <= row_phase_in;
         kept_count_ff   <= kept_count_in;
      end
   end

endmodule

FILE: rtl/core/psd_queue.sv
// ----------------------------------------------------------------------------
// psd_queue
// Short register queue between the classifier and the result stage.
// ----------------------------------------------------------------------------
module psd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  psd_pkg::entry_type push_entry,
   input  logic               pop,
   output psd_pkg::entry_type head,
   output logic               empty,
   output logic               full
);

   psd_pkg::entry_type entries_ff [psd_pkg::QUEUE_DEPTH];

   logic [psd_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [psd_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [psd_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic                            do_push, do_pop;

   always_comb begin
      empty   = (count_ff == '0);
      full    = (count_ff == psd_pkg::QUEUE_CNT_W'(psd_pkg::QUEUE_DEPTH));
      do_push = push && !full;
      do_pop  = pop && !empty;
      head    = entries_ff[rd_ptr_ff];

      wr_ptr_in = do_push ? wr_ptr_ff + psd_pkg::QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + psd_pkg::QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + psd_pkg::QUEUE_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - psd_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/core/psd_back.sv
// ----------------------------------------------------------------------------
// psd_back
// Turns queued entries into result items: the kept pixel first, then the
// padding run, through an output register.
// ----------------------------------------------------------------------------
module psd_back (
   input  logic                          clock,
   input  logic                          reset,
   input  psd_pkg::entry_type            head,
   input  logic                          empty,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [psd_pkg::PIX_W-1:0]     rsp_pixel_out,
   output logic [psd_pkg::LIM_W-1:0]     rsp_run_length,
   output logic                          rsp_line_end
);

   logic                      valid_ff, valid_in;
   logic                      second_ff, second_in;
   logic [psd_pkg::PIX_W-1:0] pixel_ff, pixel_in;
   logic [psd_pkg::LIM_W-1:0] run_ff, run_in;
   logic                      end_ff, end_in;
   logic                      load, emit, take_kept;

   always_comb begin
      load      = !valid_ff || !rsp_stall;
      emit      = load && !empty;
      take_kept = head.has_kept && !second_ff;
      // hold the entry when its padding run still has to follow
      pop       = emit && !(take_kept && head.has_pad);

      second_in = emit ? (take_kept && head.has_pad) : second_ff;
      valid_in  = emit ? 1'b1 : (load ? 1'b0 : valid_ff);

      pixel_in = pixel_ff;
      run_in   = run_ff;
      end_in   = end_ff;
      if (emit) begin
         if (take_kept) begin
            pixel_in = head.pixel;
            run_in   = psd_pkg::LIM_W'(1);
            end_in   = head.kept_end;
         end else begin
            pixel_in = '0;
            run_in   = head.pad_run;
            end_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
   end

   always_ff @(posedge clock) begin
      pixel_ff <= pixel_in;
      run_ff   <= run_in;
      end_ff   <= end_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_pixel_out  = pixel_ff;
   assign rsp_run_length = run_ff;
   assign rsp_line_end   = end_ff;

endmodule

FILE: rtl/core/pixel_stream_decimator_core.sv
// ----------------------------------------------------------------------------
// pixel_stream_decimator_core
// Nearest-neighbor decimation of a raster pixel stream by an integer step.
// ----------------------------------------------------------------------------
// Input pixels arrive in row order on the req_ channel, one per accepted
// item. Each kept pixel leaves on the rsp_ channel with run length one; when
// a kept row ends short of out_width, one zero-valued padding run fills the
// output line to out_width, and the last result of a line carries line_end.
// Registers are written over the csr_ port; the user must write them only
// while the stream is idle, which the block itself does not enforce.
// Throughput: one input item per clock while the queue has room. An input
// that closes a kept row and also keeps a pixel gives two results, which
// leave one after the other; the four-entry queue absorbs such pairs now and
// then, and a steady run of them holds the input back through req_stall.
// A result is written to the queue at the edge that accepts its input, then
// to the output register; a padding run follows the kept pixel of its input.
// Reset clears the row and column counters, the queue and the output valid
// flag, and loads the registers with in_width 512, out_width 512,
// step 1 and kept_per_line 512.
// While rsp_stall is high the result holds; the queue fills and req_stall
// rises once it is full.
// ----------------------------------------------------------------------------
module pixel_stream_decimator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write_enable,
   input  logic [psd_pkg::INDEX_W-1:0]     csr_index,
   input  logic [psd_pkg::LIM_W-1:0]       csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [psd_pkg::PIX_W-1:0]       req_pixel,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [psd_pkg::PIX_W-1:0]       rsp_pixel_out,
   output logic [psd_pkg::LIM_W-1:0]       rsp_run_length,
   output logic                            rsp_line_end
);

   psd_pkg::cfg_type   cfg_ff, cfg_in;
   psd_pkg::entry_type push_entry, head;
   logic               accept, push, pop, empty, full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (psd_pkg::csr_index_type'(csr_index))
            psd_pkg::CSR_IN_WIDTH:      cfg_in.in_width      = csr_wdata;
            psd_pkg::CSR_OUT_WIDTH:     cfg_in.out_width     = csr_wdata;
            psd_pkg::CSR_STEP:          cfg_in.step          = csr_wdata;
            psd_pkg::CSR_KEPT_PER_LINE: cfg_in.kept_per_line = csr_wdata;
            default:                    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_width      <= psd_pkg::LIM_W'(512);
         cfg_ff.out_width     <= psd_pkg::LIM_W'(512);
         cfg_ff.step          <= psd_pkg::LIM_W'(1);
         cfg_ff.kept_per_line <= psd_pkg::LIM_W'(512);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = full;
   assign accept    = req_valid && !full;

   psd_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .accept (accept),
      .pixel  (req_pixel),
      .push   (push),
      .entry  (push_entry)
   );

   psd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   psd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .empty          (empty),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_run_length (rsp_run_length),
      .rsp_line_end   (rsp_line_end)
   );

endmodule

FILE: sim/psd_result_checker.sv
// ----------------------------------------------------------------------------
// psd_result_checker
// Watches the register port and both streams of the pixel stream decimator,
// keeps its own copy of the registers and counters, works out the results
// of every accepted input item and compares each accepted result with the
// oldest one still due.
// ----------------------------------------------------------------------------
module psd_result_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_enable,
   input  logic [psd_pkg::INDEX_W-1:0]  csr_index,
   input  logic [psd_pkg::LIM_W-1:0]    csr_wdata,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [psd_pkg::PIX_W-1:0]    req_pixel,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [psd_pkg::PIX_W-1:0]    rsp_pixel_out,
   input  logic [psd_pkg::LIM_W-1:0]    rsp_run_length,
   input  logic                         rsp_line_end,
   output int unsigned                  fail_count,
   output int unsigned                  pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [psd_pkg::PIX_W-1:0] pixel;
      logic [psd_pkg::LIM_W-1:0] run_length;
      logic                      line_end;
   } out_pixel_type;

   out_pixel_type             expected_pixels[$];
   psd_pkg::cfg_type          regs;
   logic [psd_pkg::CNT_W-1:0] column_count;
   logic [psd_pkg::CNT_W-1:0] column_phase;
   logic [psd_pkg::CNT_W-1:0] row_phase;
   logic [psd_pkg::LIM_W-1:0] kept_count;

   initial begin
      fail_count    = 0;
      pending_count = 0;
   end

   // effective register value: saturate at the maximum width, zero may read as one
   function automatic int unsigned limit_of(input logic [psd_pkg::LIM_W-1:0] v,
                                            input bit at_least_one);
      int unsigned r;
      r = (v > psd_pkg::MAX_WIDTH) ? psd_pkg::MAX_WIDTH : int'(v);
      if (at_least_one && r == 0) begin
         r = 1;
      end
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      fail_count++;
   endtask

   always @(posedge clock) begin : watch
      int unsigned   iw;
      int unsigned   ow;
      int unsigned   st;
      int unsigned   kp;
      bit            row_kept;
      bit            row_end;
      out_pixel_type want;
      out_pixel_type seen;

      if (reset) begin
         regs.in_width      = psd_pkg::LIM_W'(512);
         regs.out_width     = psd_pkg::LIM_W'(512);
         regs.step          = psd_pkg::LIM_W'(1);
         regs.kept_per_line = psd_pkg::LIM_W'(512);
         column_count       = '0;
         column_phase       = '0;
         row_phase          = '0;
         kept_count         = '0;
         expected_pixels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               psd_pkg::CSR_IN_WIDTH:      regs.in_width      = csr_wdata;
               psd_pkg::CSR_OUT_WIDTH:     regs.out_width     = csr_wdata;
               psd_pkg::CSR_STEP:          regs.step          = csr_wdata;
               psd_pkg::CSR_KEPT_PER_LINE: regs.kept_per_line = csr_wdata;
               default: ;
            endcase
         end

         if (req_valid && !req_stall) begin
            iw = limit_of(regs.in_width, 1'b1);
            ow = limit_of(regs.out_width, 1'b1);
            st = limit_of(regs.step, 1'b1);
            kp = limit_of(regs.kept_per_line, 1'b0);
            if (kp > ow) begin
               kp = ow;
            end
            row_kept = (row_phase == '0);
            row_end  = (int'(column_count) + 1 >= iw);

            if (row_kept && column_phase == '0 && kept_count < kp) begin
               want.pixel      = req_pixel & psd_pkg::PIX_MASK;
               want.run_length = psd_pkg::LIM_W'(1);
               want.line_end   = (int'(kept_count) + 1 >= ow);
               expected_pixels.push_back(want);
               kept_count++;
            end

            if (row_end) begin
               // pad the rest of a kept line with one zero run
               if (row_kept && kept_count < ow) begin
                  want.pixel      = '0;
                  want.run_length = psd_pkg::LIM_W'(ow - kept_count);
                  want.line_end   = 1'b1;
                  expected_pixels.push_back(want);
               end
               column_count = '0;
               column_phase = '0;
               kept_count   = '0;
               row_phase    = (int'(row_phase) + 1 >= st) ? '0 : row_phase + 1'b1;
            end else begin
               column_count++;
               column_phase = (int'(column_phase) + 1 >= st) ? '0 : column_phase + 1'b1;
            end
         end

         if (rsp_valid && !rsp_stall) begin
            seen = '{rsp_pixel_out, rsp_run_length, rsp_line_end};
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("unexpected item pixel %06h run %0d end %0b",
                                         seen.pixel, seen.run_length, seen.line_end));
            end else begin
               want = expected_pixels.pop_front();
               if (seen !== want) begin
                  report_mismatch($sformatf(
                     "pixel %06h/%06h run %0d/%0d end %0b/%0b (got/expected)",
                     seen.pixel, want.pixel, seen.run_length, want.run_length,
                     seen.line_end, want.line_end));
               end
            end
         end
      end
      pending_count = expected_pixels.size();
   end

endmodule

FILE: sim/pixel_stream_decimator_core_tb.sv
// ----------------------------------------------------------------------------
// pixel_stream_decimator_core_tb
// Drives register settings and pixel rows into the decimator core under
// random idling on both streams; a checker beside the core predicts and
// compares every result.
// ----------------------------------------------------------------------------
module pixel_stream_decimator_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                        clock            = 1'b0;
   logic                        reset            = 1'b1;
   logic                        csr_write_enable = 1'b0;
   logic [psd_pkg::INDEX_W-1:0] csr_index        = '0;
   logic [psd_pkg::LIM_W-1:0]   csr_wdata        = '0;
   logic                        req_valid        = 1'b0;
   logic                        req_stall;
   logic [psd_pkg::PIX_W-1:0]   req_pixel        = '0;
   logic                        rsp_valid;
   logic                        rsp_stall        = 1'b0;
   logic [psd_pkg::PIX_W-1:0]   rsp_pixel_out;
   logic [psd_pkg::LIM_W-1:0]   rsp_run_length;
   logic                        rsp_line_end;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned gap_pct   = 0;
   int unsigned stall_pct = 0;
   int unsigned pixels_sent = 0;

   pixel_stream_decimator_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_run_length   (rsp_run_length),
      .rsp_line_end     (rsp_line_end)
   );

   psd_result_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pixel        (req_pixel),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_run_length   (rsp_run_length),
      .rsp_line_end     (rsp_line_end),
      .fail_count       (fail_count),
      .pending_count    (pending_count)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_pct);
   end

   // write all four registers on consecutive edges, enable held throughout
   task automatic write_config(input logic [psd_pkg::LIM_W-1:0] in_w,
                               input logic [psd_pkg::LIM_W-1:0] out_w,
                               input logic [psd_pkg::LIM_W-1:0] st,
                               input logic [psd_pkg::LIM_W-1:0] kept);
      csr_write_enable <= 1'b1;
      csr_index        <= psd_pkg::CSR_IN_WIDTH;
      csr_wdata        <= in_w;
      @(posedge clock);
      csr_index        <= psd_pkg::CSR_OUT_WIDTH;
      csr_wdata        <= out_w;
      @(posedge clock);
      csr_index        <= psd_pkg::CSR_STEP;
      csr_wdata        <= st;
      @(posedge clock);
      csr_index        <= psd_pkg::CSR_KEPT_PER_LINE;
      csr_wdata        <= kept;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_pixel(input logic [psd_pkg::PIX_W-1:0] p);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pixel <= p;
      do @(posedge clock); while (req_stall);
      pixels_sent++;
   endtask

   // drop valid, let every result drain, then give the core time to settle
   task automatic drain;
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [psd_pkg::LIM_W-1:0] pick_limit(input int unsigned small_hi);
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return psd_pkg::LIM_W'(psd_pkg::MAX_WIDTH);
         2:       return psd_pkg::LIM_W'($urandom_range(psd_pkg::MAX_WIDTH + 1, 8191));
         3:       return '1;
         default: return psd_pkg::LIM_W'($urandom_range(1, small_hi));
      endcase
   endfunction

   function automatic logic [psd_pkg::PIX_W-1:0] random_pixel;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return psd_pkg::PIX_W'($urandom);
      endcase
   endfunction

   initial begin : stimulus
      logic [psd_pkg::LIM_W-1:0] in_w;
      logic [psd_pkg::LIM_W-1:0] out_w;
      logic [psd_pkg::LIM_W-1:0] st;
      logic [psd_pkg::LIM_W-1:0] kept;
      int unsigned               row_len;
      int unsigned               step_eff;
      int unsigned               count;
      int unsigned               waited;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // short line with more kept pixels allowed than the row supplies: pad of two
      write_config(psd_pkg::LIM_W'(3), psd_pkg::LIM_W'(5), psd_pkg::LIM_W'(1), '1);
      send_pixel('0);
      send_pixel('1);
      send_pixel(24'hA5A5A5);
      drain();
      // kept pixels fill the line, no padding run
      write_config(psd_pkg::LIM_W'(3), psd_pkg::LIM_W'(2), psd_pkg::LIM_W'(1), '1);
      repeat (3) send_pixel(random_pixel());
      drain();
      // zero registers read as one, zero kept count
      write_config('0, '0, '0, '0);
      repeat (2) send_pixel(random_pixel());
      drain();
      // saturated output width, every other row dropped
      write_config(psd_pkg::LIM_W'(4), '1, psd_pkg::LIM_W'(2), psd_pkg::LIM_W'(1));
      repeat (8) send_pixel(random_pixel());
      drain();
      // saturated step; stop two pixels into a dropped row
      write_config(psd_pkg::LIM_W'(5), psd_pkg::LIM_W'(3), '1, psd_pkg::LIM_W'(5));
      repeat (7) send_pixel(random_pixel());
      drain();

      while (pixels_sent < 1950) begin
         in_w  = pick_limit(12);
         out_w = pick_limit(16);
         st    = pick_limit(4);
         kept  = pick_limit(16);
         write_config(in_w, out_w, st, kept);

         case ($urandom_range(0, 3))
            0: begin gap_pct = 0;  stall_pct <= 0;  end
            1: begin gap_pct = 59; stall_pct <= 0;  end
            2: begin gap_pct = 0;  stall_pct <= 59; end
            default: begin gap_pct = 18; stall_pct <= 18; end
         endcase

         row_len  = (in_w == '0) ? 1 : int'(in_w);
         step_eff = (st == '0) ? 1 : ((st > 8) ? 8 : int'(st));
         if (row_len > 12) begin
            count = $urandom_range(5, 40);
         end else begin
            // whole rows so that kept rows come round
            count = row_len * $urandom_range(1, 2 * step_eff + 1);
         end
         if ($urandom_range(0, 3) == 0) begin
            count = $urandom_range(1, 30);
         end

         repeat (count) send_pixel(random_pixel());
         drain();
      end

      gap_pct = 0;
      stall_pct <= 0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending_count != 0 && waited < 20000);

      if (pending_count != 0) begin
         $display("FAIL pixel_stream_decimator_core");
         $finish;
      end else begin
         repeat (10) @(negedge clock);
         if (fail_count == 0) begin
            $display("PASS pixel_stream_decimator_core");
         end else begin
            $display("FAIL pixel_stream_decimator_core");
         end
         $finish;
      end
   end

   initial begin : watchdog
      #5ms;
      $display("FAIL pixel_stream_decimator_core");
      $finish;
   end

endmodule
